// File: rtl/bfm_pkg.sv
// Package: shared constants, item types and cell control for the flow-shop makespan core.
`default_nettype none
package bfm_pkg;
    localparam int MAX_MACHINES = 16;
    localparam int MAX_JOBS     = 256;
    localparam int JOB_AW       = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int MACH_IW      = 4;
    localparam int CNT_W        = 5;
    localparam int MACH_SW      = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
    localparam int TIME_W       = 16;
    localparam int COMP_W       = 32;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [8:0]        job_number;
        logic [3:0]        machine_index;
        logic [TIME_W-1:0] proc_time;
        logic              first_job;
        logic              last_job;
    } t_in_item;

    typedef struct packed {
        logic [COMP_W-1:0] job_completion;
        logic              is_makespan;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic rd_en;
        logic zero_p;
        logic is_last;
    } t_cell_ctl;
endpackage
`default_nettype wire

// File: rtl/bfm_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module bfm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/bfm_cell.sv
// One machine cell: processing-time column, completion register and chain step.
`default_nettype none
module bfm_cell
    import bfm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic              i_we,
    input  wire logic [JOB_AW-1:0] i_waddr,
    input  wire logic [TIME_W-1:0] i_wdata,
    input  wire logic [JOB_AW-1:0] i_raddr,
    input  wire logic              i_tok,
    input  wire logic [COMP_W-1:0] i_cur,
    input  wire logic [COMP_W-1:0] i_mc_next,
    output logic                   o_tok,
    output logic      [COMP_W-1:0] o_cur,
    output logic      [COMP_W-1:0] o_mc,
    output logic                   o_done
);
    logic [TIME_W-1:0] ram_q;
    logic [TIME_W-1:0] p;
    logic [COMP_W-1:0] raised;
    logic [COMP_W:0]   wide;
    logic [COMP_W-1:0] sum;
    logic [COMP_W-1:0] r_mc, n_mc;
    logic [COMP_W-1:0] r_cur, n_cur;
    logic              r_tok, n_tok;
    logic              r_wait, n_wait;
    logic              r_done, n_done;

    bfm_ram #(.WIDTH(TIME_W), .DEPTH(MAX_JOBS), .AW(JOB_AW)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_we),
        .i_waddr(i_waddr),
        .i_wdata(i_wdata),
        .i_re   (i_ctl.rd_en),
        .i_raddr(i_raddr),
        .o_rdata(ram_q)
    );

    always_comb begin
        p      = i_ctl.zero_p ? '0 : ram_q;
        raised = (i_cur > r_mc) ? i_cur : r_mc;
        wide   = {1'b0, raised} + {{(COMP_W + 1 - TIME_W){1'b0}}, p};
        sum    = wide[COMP_W] ? '1 : wide[COMP_W-1:0];
    end

    always_comb begin
        n_mc   = r_mc;
        n_cur  = r_cur;
        n_tok  = 1'b0;
        n_wait = 1'b0;
        n_done = 1'b0;
        if (i_ctl.clear) begin
            n_mc = '0;
        end
        if (r_wait) begin
            // departure from this machine waits for the next machine to free up
            n_mc = (r_cur > i_mc_next) ? r_cur : i_mc_next;
        end
        if (i_tok) begin
            n_cur = sum;
            if (i_ctl.is_last) begin
                n_mc   = sum;
                n_done = 1'b1;
            end else begin
                n_tok  = 1'b1;
                n_wait = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mc   <= '0;
            r_tok  <= 1'b0;
            r_wait <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mc   <= n_mc;
            r_tok  <= n_tok;
            r_wait <= n_wait;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    assign o_tok  = r_tok;
    assign o_cur  = r_cur;
    assign o_mc   = r_mc;
    assign o_done = r_done;
endmodule
`default_nettype wire

// File: rtl/blocking_flowshop_makespan_core.sv
// Top level: flow-shop-with-blocking makespan core, one cell per machine.
// Load item: accepted whenever busy is low, and busy stays low.
// Evaluate item: result strobed once the token has passed every machine in use;
// busy drops during the strobe cycle, so a new evaluate is taken only from then on, paced by the
// token walking the cell chain one machine per cycle. The receiver cannot stall.
// Reset: completions cleared, machine_count 16; the time table is not cleared.
`default_nettype none
module blocking_flowshop_makespan_core
    import bfm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire t_in_item         i_item,
    output logic                  o_done,
    output t_out_item             o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [CNT_W-1:0] i_cfg_data
);
    logic                  accept;
    logic                  eval_go;
    logic                  job_ok;
    logic [8:0]            job_m1;
    logic [JOB_AW-1:0]     addr;
    logic                  load_ok;
    logic [MACH_SW-1:0]    last_idx;
    logic [CNT_W-1:0]      r_mcount;
    logic                  r_busy, n_busy;
    logic                  r_go;
    logic                  r_zero_p;
    logic                  r_makespan;
    logic                  done_any;
    logic [COMP_W-1:0]     res_val;

    logic [MAX_MACHINES:0] tok;
    logic [COMP_W-1:0]     cur  [MAX_MACHINES+1];
    logic [COMP_W-1:0]     mc   [MAX_MACHINES+1];
    logic [MAX_MACHINES-1:0] done;
    t_cell_ctl             ctl  [MAX_MACHINES];

    assign accept  = i_start && !o_busy;
    assign eval_go = accept && (i_item.req_type == REQ_EVAL);
    assign job_ok  = (i_item.job_number != 9'd0) &&
                     (i_item.job_number <= 9'(MAX_JOBS));
    assign job_m1  = i_item.job_number - 9'd1;
    assign addr    = job_m1[JOB_AW-1:0];
    assign load_ok = accept && (i_item.req_type == REQ_LOAD) && job_ok &&
                     ({1'b0, i_item.machine_index} < 5'(MAX_MACHINES));

    always_comb begin
        priority if (r_mcount == '0) begin
            last_idx = '0;
        end else if (r_mcount > CNT_W'(MAX_MACHINES)) begin
            last_idx = MACH_SW'(MAX_MACHINES - 1);
        end else begin
            last_idx = MACH_SW'(r_mcount - CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcount <= CNT_W'(16);
        end else if (i_cfg_valid) begin
            r_mcount <= i_cfg_data;
        end
    end
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_busy = r_busy;
        if (done_any) begin
            n_busy = 1'b0;
        end
        if (eval_go) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_go   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_go   <= eval_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_go) begin
            r_zero_p   <= !job_ok;
            r_makespan <= i_item.last_job;
        end
    end

    assign tok[0]            = r_go;
    assign cur[0]            = '0;
    assign mc[MAX_MACHINES]  = '0;

    for (genvar k = 0; k < MAX_MACHINES; k++) begin : g_cell
        always_comb begin
            ctl[k].clear   = eval_go && i_item.first_job;
            ctl[k].rd_en   = eval_go;
            ctl[k].zero_p  = r_zero_p;
            ctl[k].is_last = (last_idx == MACH_SW'(k));
        end

        bfm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl[k]),
            .i_we     (load_ok && (i_item.machine_index == MACH_IW'(k))),
            .i_waddr  (addr),
            .i_wdata  (i_item.proc_time),
            .i_raddr  (addr),
            .i_tok    (tok[k]),
            .i_cur    (cur[k]),
            .i_mc_next(mc[k+1]),
            .o_tok    (tok[k+1]),
            .o_cur    (cur[k+1]),
            .o_mc     (mc[k]),
            .o_done   (done[k])
        );
    end

    always_comb begin
        res_val = '0;
        for (int k = 0; k < MAX_MACHINES; k++) begin
            res_val = res_val | (done[k] ? cur[k+1] : '0);
        end
    end

    assign done_any                = |done;
    assign o_busy                  = r_busy && !done_any;
    assign o_done                  = done_any;
    assign o_result.job_completion = res_val;
    assign o_result.is_makespan    = r_makespan;
endmodule
`default_nettype wire

// File: sim/blocking_flowshop_makespan_core_test.sv
// Testbench for the flow-shop-with-blocking makespan core: schedules, loads and odd fields.
`default_nettype none
module blocking_flowshop_makespan_core_test
    import bfm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 1200;
    localparam int SETTLE       = MAX_MACHINES + 4;

    class makespan_scoreboard;
        bit [TIME_W-1:0] times [MAX_MACHINES][MAX_JOBS];
        bit              written [MAX_MACHINES][MAX_JOBS];
        bit [COMP_W-1:0] completion [MAX_MACHINES];
        bit [CNT_W-1:0]  machines;
        t_out_item       completions_due [$];
        int              errors;
        int              results_checked;

        function new();
            foreach (completion[m]) completion[m] = '0;
            foreach (written[m, j]) written[m][j] = 1'b0;
            machines        = CNT_W'(MAX_MACHINES);
            errors          = 0;
            results_checked = 0;
        endfunction

        function void set_machines(bit [CNT_W-1:0] v);
            machines = v;
        endfunction

        function int active_machines();
            if (machines == 0) return 1;
            if (machines > MAX_MACHINES) return MAX_MACHINES;
            return int'(machines);
        endfunction

        function bit job_ready(bit [8:0] job);
            for (int m = 0; m < active_machines(); m++) begin
                if (!written[m][job - 1]) return 1'b0;
            end
            return 1'b1;
        endfunction

        function bit [COMP_W-1:0] sat_add(bit [COMP_W-1:0] a, bit [COMP_W-1:0] b);
            bit [COMP_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[COMP_W] ? {COMP_W{1'b1}} : s[COMP_W-1:0];
        endfunction

        function int outstanding();
            return completions_due.size();
        endfunction

        function void note_item(t_in_item it);
            bit              job_ok;
            int              n;
            bit [COMP_W-1:0] cur;
            bit [COMP_W-1:0] pt;
            t_out_item       due;
            job_ok = (it.job_number >= 1) && (it.job_number <= MAX_JOBS);
            if (it.req_type == REQ_LOAD) begin
                if (job_ok && it.machine_index < MAX_MACHINES) begin
                    times[it.machine_index][it.job_number - 1]   = it.proc_time;
                    written[it.machine_index][it.job_number - 1] = 1'b1;
                end
                return;
            end
            if (it.first_job) begin
                foreach (completion[m]) completion[m] = '0;
            end
            n   = active_machines();
            pt  = job_ok ? COMP_W'(times[0][it.job_number - 1]) : '0;
            cur = sat_add(completion[0], pt);
            for (int m = 1; m < n; m++) begin
                if (cur < completion[m]) cur = completion[m];
                completion[m - 1] = cur;
                pt  = job_ok ? COMP_W'(times[m][it.job_number - 1]) : '0;
                cur = sat_add(cur, pt);
            end
            completion[n - 1]  = cur;
            due.job_completion = cur;
            due.is_makespan    = it.last_job;
            completions_due.push_back(due);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (completions_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d/%0b",
                         $time, got.job_completion, got.is_makespan);
                return;
            end
            want = completions_due.pop_front();
            results_checked++;
            if (got.job_completion !== want.job_completion) begin
                errors++;
                $display("%0t: job_completion mismatch, expected %0d, actual %0d",
                         $time, want.job_completion, got.job_completion);
            end
            if (got.is_makespan !== want.is_makespan) begin
                errors++;
                $display("%0t: is_makespan mismatch, expected %0b, actual %0b",
                         $time, want.is_makespan, got.is_makespan);
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_start;
    logic             o_busy;
    t_in_item         i_item;
    logic             o_done;
    t_out_item        o_result;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [CNT_W-1:0] i_cfg_data;

    makespan_scoreboard board = new();
    int  cycle_count = 0;
    int  accepted    = 0;
    int  counted     = 0;
    int  settings    = 0;
    bit  dense       = 1'b0;

    blocking_flowshop_makespan_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            board.check_result(o_result);
        end
    end

    function automatic logic [TIME_W-1:0] rand_time();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return TIME_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [8:0] bad_job();
        if ($urandom_range(0, 3) == 0) return 9'd0;
        return 9'($urandom_range(MAX_JOBS + 1, 511));
    endfunction

    function automatic int gap_len();
        int r;
        if (dense) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 9);
        unique case (r)
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'd31;
            4: return 5'($urandom_range(17, 30));
            5: return 5'($urandom_range(8, 15));
            default: return 5'($urandom_range(2, 6));
        endcase
    endfunction

    function automatic t_in_item load_item(logic [8:0] job, logic [3:0] mach,
                                           logic [TIME_W-1:0] t);
        t_in_item it;
        it.req_type      = REQ_LOAD;
        it.job_number    = job;
        it.machine_index = mach;
        it.proc_time     = t;
        it.first_job     = 1'($urandom_range(0, 1));
        it.last_job      = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic t_in_item eval_item(logic [8:0] job, logic first, logic last);
        t_in_item it;
        it.req_type      = REQ_EVAL;
        it.job_number    = job;
        it.machine_index = 4'($urandom_range(0, 15));
        it.proc_time     = TIME_W'($urandom_range(0, 65535));
        it.first_job     = first;
        it.last_job      = last;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        board.note_item(it);
        accepted++;
    endtask

    task automatic pause_sender(input int n);
        if (n > 0) begin
            i_start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic do_item(input t_in_item it);
        bit ignored;
        ignored = (it.req_type == REQ_LOAD) &&
                  (it.job_number == 0 || it.job_number > MAX_JOBS);
        send_item(it);
        if (!ignored) counted++;
        pause_sender(gap_len());
    endtask

    task automatic wait_for_results();
        i_start <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_machines(input logic [CNT_W-1:0] v);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        board.set_machines(v);
        settings++;
    endtask

    task automatic run_schedule();
        int         k;
        int         n;
        logic [8:0] j;
        logic [8:0] jobs [$];
        logic       first_flag;
        k = $urandom_range(1, 6);
        n = board.active_machines();
        dense = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < k; i++) begin
            j = 9'($urandom_range(1, MAX_JOBS));
            jobs.push_back(j);
            for (int m = 0; m < n; m++) begin
                if (!board.written[m][j - 1] || $urandom_range(0, 15) == 0)
                    do_item(load_item(j, 4'(m), rand_time()));
            end
        end
        first_flag = ($urandom_range(0, 9) != 0);
        foreach (jobs[i]) begin
            do_item(eval_item(jobs[i], (i == 0) ? first_flag : 1'b0, i == jobs.size() - 1));
        end
        dense = 1'b0;
    endtask

    task automatic run_noise();
        int         r;
        logic [8:0] j;
        r = $urandom_range(0, 2);
        unique case (r)
            0: do_item(load_item(bad_job(), 4'($urandom_range(0, 15)), rand_time()));
            1: do_item(eval_item(bad_job(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            default: begin
                j = 9'($urandom_range(1, MAX_JOBS));
                if (!board.job_ready(j)) j = bad_job();
                do_item(eval_item(j, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
        endcase
    endtask

    initial begin
        int start_count;
        int last_cfg;
        int r;
        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, ignored loads, out-of-range jobs, count clamping
        write_machines(5'd3);
        do_item(load_item(9'd1, 4'd0, 16'hFFFF));
        do_item(load_item(9'd1, 4'd1, 16'h0000));
        do_item(load_item(9'd1, 4'd2, 16'd12345));
        do_item(load_item(9'd256, 4'd0, 16'd1));
        do_item(load_item(9'd256, 4'd1, 16'hFFFF));
        do_item(load_item(9'd256, 4'd2, 16'h0000));
        do_item(load_item(9'd256, 4'd15, 16'hFFFF));
        do_item(load_item(9'd0, 4'd5, 16'd777));
        do_item(load_item(9'd257, 4'd0, 16'd1));
        do_item(load_item(9'd511, 4'd15, 16'hFFFF));
        do_item(eval_item(9'd1, 1'b1, 1'b0));
        do_item(eval_item(9'd256, 1'b0, 1'b1));
        do_item(eval_item(9'd0, 1'b1, 1'b1));
        do_item(eval_item(9'd511, 1'b0, 1'b1));
        do_item(eval_item(9'd256, 1'b1, 1'b0));
        do_item(eval_item(9'd1, 1'b0, 1'b1));
        write_machines(5'd0);
        do_item(eval_item(9'd1, 1'b1, 1'b1));
        do_item(eval_item(9'd256, 1'b0, 1'b0));
        write_machines(5'd31);
        do_item(eval_item(9'd257, 1'b1, 1'b1));

        start_count = counted;
        last_cfg    = counted;
        write_machines(pick_count());
        while (counted - start_count < RANDOM_ITEMS) begin
            if (counted - last_cfg >= 150) begin
                write_machines(pick_count());
                last_cfg = counted;
            end
            r = $urandom_range(0, 99);
            if (r < 78) run_schedule();
            else if (r < 96) run_noise();
            else wait_for_results();
        end
        write_machines(5'd16);
        run_schedule();

        wait_for_results();
        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d items, %0d results checked, %0d machine-count settings,",
                 accepted, board.results_checked, settings);
        $display("with ignored loads, out-of-range jobs and clamped machine counts.");
        if (board.errors == 0 && board.outstanding() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
